### src/dssm_pkg.sv
// package for the dual stack shared memory block
// holds state, command, flag types and the operation and status codes; no dependencies
package dssm_pkg;

    localparam int DefaultDepth = 1024;
    localparam int WordW        = 32;
    localparam int HeightW      = 11;
    localparam int KindW        = 2;
    localparam int StatusW      = 2;

    localparam logic [KindW-1:0] KIND_PUSH_ONE = 2'd0;
    localparam logic [KindW-1:0] KIND_PUSH_TWO = 2'd1;
    localparam logic [KindW-1:0] KIND_POP_ONE  = 2'd2;
    localparam logic [KindW-1:0] KIND_POP_TWO  = 2'd3;

    localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
    localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
    localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDWAIT,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic pop_go;
    } flags_t;

endpackage

### src/dssm_ram.sv
// generic single port ram with registered read data
// no dependencies
module dssm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/dssm_ctrl.sv
// controller state machine for the dual stack shared memory block
// depends on dssm_pkg
module dssm_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  dssm_pkg::flags_t flags,
    output dssm_pkg::cmd_t   cmd
);
    import dssm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.exec    = 1'b0;
        cmd.capture = 1'b0;
        s_ready     = 1'b0;
        m_valid     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = flags.pop_go ? ST_RDWAIT : ST_RESP;
            end
            ST_RDWAIT: begin
                cmd.capture = 1'b1;
                state_next  = ST_RESP;
            end
            ST_RESP: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_exec_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.exec)
        else $error("exec did not follow load");
    a_pop_read_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && flags.pop_go |=> cmd.capture ##1 m_valid)
        else $error("pop read not captured before response");
    a_no_ready_with_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request taken while result pending");
`endif

endmodule

### src/dssm_datapath.sv
// datapath: stack heights, address generation, result registers, shared word ram
// depends on dssm_pkg and dssm_ram
module dssm_datapath #(
    parameter int DEPTH = dssm_pkg::DefaultDepth
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  dssm_pkg::cmd_t                       cmd,
    output dssm_pkg::flags_t                     flags,
    input  logic [dssm_pkg::KindW-1:0]           s_kind,
    input  logic signed [dssm_pkg::WordW-1:0]    s_push_value,
    output logic signed [dssm_pkg::WordW-1:0]    m_pop_value,
    output logic [dssm_pkg::StatusW-1:0]         m_status,
    output logic [dssm_pkg::HeightW-1:0]         m_height_one,
    output logic [dssm_pkg::HeightW-1:0]         m_height_two
);
    import dssm_pkg::*;

    localparam int AddrW = $clog2(DEPTH);
    localparam int CntW  = $clog2(DEPTH + 1);
    localparam logic [CntW:0] DepthC = (CntW + 1)'(DEPTH);

    logic [KindW-1:0]   kind_reg;
    logic [WordW-1:0]   value_reg;
    logic [CntW-1:0]    count_one_reg;
    logic [CntW-1:0]    count_one_next;
    logic [CntW-1:0]    count_two_reg;
    logic [CntW-1:0]    count_two_next;
    logic [WordW-1:0]   pop_value_reg;
    logic [StatusW-1:0] status_reg;

    logic [CntW:0]      c1_ext;
    logic [CntW:0]      c2_ext;
    logic [CntW:0]      total;
    logic [CntW:0]      addr_wide;
    logic               full;
    logic               op_ok;
    logic               is_pop;
    logic               ram_en;
    logic               ram_we;
    logic [WordW-1:0]   ram_rdata;
    logic [CntW+HeightW-1:0] h1_ext;
    logic [CntW+HeightW-1:0] h2_ext;

    assign c1_ext = {1'b0, count_one_reg};
    assign c2_ext = {1'b0, count_two_reg};
    assign total  = c1_ext + c2_ext;
    assign full   = (total >= DepthC);
    assign is_pop = kind_reg[1];

    always_comb begin
        op_ok          = 1'b0;
        addr_wide      = c1_ext;
        count_one_next = count_one_reg;
        count_two_next = count_two_reg;
        case (kind_reg)
            KIND_PUSH_ONE: begin
                op_ok          = !full;
                addr_wide      = c1_ext;
                count_one_next = count_one_reg + 1'b1;
            end
            KIND_PUSH_TWO: begin
                op_ok          = !full;
                addr_wide      = DepthC - 1'b1 - c2_ext;
                count_two_next = count_two_reg + 1'b1;
            end
            KIND_POP_ONE: begin
                op_ok          = (count_one_reg != '0);
                addr_wide      = c1_ext - 1'b1;
                count_one_next = count_one_reg - 1'b1;
            end
            KIND_POP_TWO: begin
                op_ok          = (count_two_reg != '0);
                addr_wide      = DepthC - c2_ext;
                count_two_next = count_two_reg - 1'b1;
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    assign flags.pop_go = op_ok && is_pop;
    assign ram_en       = cmd.exec && op_ok;
    assign ram_we       = ram_en && !is_pop;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= s_kind;
            value_reg <= s_push_value;
        end
        if (cmd.exec) begin
            pop_value_reg <= '1;
            if (op_ok) begin
                status_reg <= STATUS_OK;
            end else begin
                status_reg <= is_pop ? STATUS_EMPTY : STATUS_FULL;
            end
        end
        if (cmd.capture) begin
            pop_value_reg <= ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_one_reg <= '0;
            count_two_reg <= '0;
        end else if (cmd.exec && op_ok) begin
            count_one_reg <= count_one_next;
            count_two_reg <= count_two_next;
        end
    end

    dssm_ram #(
        .WIDTH(WordW),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .en   (ram_en),
        .we   (ram_we),
        .addr (addr_wide[AddrW-1:0]),
        .wdata(value_reg),
        .rdata(ram_rdata)
    );

    assign h1_ext       = {{HeightW{1'b0}}, count_one_reg};
    assign h2_ext       = {{HeightW{1'b0}}, count_two_reg};
    assign m_height_one = h1_ext[HeightW-1:0];
    assign m_height_two = h2_ext[HeightW-1:0];
    assign m_pop_value  = pop_value_reg;
    assign m_status     = status_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        total <= DepthC)
        else $error("stacks overlap");
    a_refused_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && !op_ok |=> $stable(count_one_reg) && $stable(count_two_reg))
        else $error("refused request changed a height");
    a_pop_one_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && op_ok && kind_reg == KIND_POP_ONE
        |=> count_one_reg == $past(count_one_reg) - 1'b1)
        else $error("pop on stack one did not decrement");
    a_push_two_inc: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && op_ok && kind_reg == KIND_PUSH_TWO
        |=> count_two_reg == $past(count_two_reg) + 1'b1)
        else $error("push on stack two did not increment");
`endif

endmodule

### src/dual_stack_shared_memory_top.sv
// top level of the dual stack shared memory block
// depends on dssm_pkg, dssm_ctrl, dssm_datapath (and through it dssm_ram)
//
//   channel   direction   handshake            payload
//   s_        in          s_valid / s_ready    s_kind, s_push_value
//   m_        out         m_valid / m_ready    m_pop_value, m_status, m_height_one/two
//
// one request at a time: accept, execute, respond
// push and refused requests go accept, execute, respond; pops that read add a capture step
// after execute, needed by the registered read port of the shared ram
// a stalled result holds and s_ready stays low until it is taken
// synchronous active-low reset clears both heights; ram contents are not cleared
module dual_stack_shared_memory_top #(
    parameter int DEPTH = dssm_pkg::DefaultDepth
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [dssm_pkg::KindW-1:0]        s_kind,
    input  logic signed [dssm_pkg::WordW-1:0] s_push_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [dssm_pkg::WordW-1:0] m_pop_value,
    output logic [dssm_pkg::StatusW-1:0]      m_status,
    output logic [dssm_pkg::HeightW-1:0]      m_height_one,
    output logic [dssm_pkg::HeightW-1:0]      m_height_two
);
    import dssm_pkg::*;

    cmd_t   cmd;
    flags_t flags;

    dssm_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .flags  (flags),
        .cmd    (cmd)
    );

    dssm_datapath #(
        .DEPTH(DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .flags       (flags),
        .s_kind      (s_kind),
        .s_push_value(s_push_value),
        .m_pop_value (m_pop_value),
        .m_status    (m_status),
        .m_height_one(m_height_one),
        .m_height_two(m_height_two)
    );

endmodule

### tb/tb_dual_stack_shared_memory_top.sv
// self-checking testbench for dual_stack_shared_memory_top: a directed request table, then
// random push/pop traffic that fills, swaps and overflows the two stacks, checked against a
// behavioral model of both stacks; depends on dssm_pkg and the rtl under src
module tb_dual_stack_shared_memory_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dssm_pkg::*;

    localparam int Depth      = DefaultDepth;
    localparam int CycleLimit = 600000;
    localparam int TableRows  = 21;

    typedef struct packed {
        logic [WordW-1:0]   pop_value;
        logic [StatusW-1:0] status;
        logic [HeightW-1:0] height_one;
        logic [HeightW-1:0] height_two;
    } stack_result_t;

    typedef struct packed {
        logic [KindW-1:0] kind;
        logic [WordW-1:0] value;
        logic             known;
        stack_result_t    result;
    } request_row_t;

    logic                       aclk         = 1'b0;
    logic                       aresetn      = 1'b0;
    logic                       s_valid      = 1'b0;
    logic                       s_ready;
    logic [KindW-1:0]           s_kind       = KIND_PUSH_ONE;
    logic signed [WordW-1:0]    s_push_value = '0;
    logic                       m_valid;
    logic                       m_ready      = 1'b0;
    logic signed [WordW-1:0]    m_pop_value;
    logic [StatusW-1:0]         m_status;
    logic [HeightW-1:0]         m_height_one;
    logic [HeightW-1:0]         m_height_two;

    logic [WordW-1:0]           shadow_words [Depth];
    int unsigned                level_one    = 0;
    int unsigned                level_two    = 0;
    stack_result_t              pending_q [$];
    int                         errors       = 0;
    int                         cycles       = 0;
    int                         tx_max       = 0;
    int                         rx_max       = 0;

    request_row_t request_table [TableRows] = '{
        {KIND_POP_ONE,  32'h0000_0000, 1'b1, 32'hFFFF_FFFF, STATUS_EMPTY, 11'd0, 11'd0},
        {KIND_POP_TWO,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, STATUS_EMPTY, 11'd0, 11'd0},
        {KIND_PUSH_ONE, 32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, STATUS_OK,    11'd1, 11'd0},
        {KIND_PUSH_TWO, 32'h8000_0000, 1'b1, 32'hFFFF_FFFF, STATUS_OK,    11'd1, 11'd1},
        {KIND_POP_ONE,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, STATUS_OK,    11'd0, 11'd1},
        {KIND_POP_TWO,  32'h0000_0000, 1'b1, 32'h8000_0000, STATUS_OK,    11'd0, 11'd0},
        {KIND_POP_TWO,  32'h5555_5555, 1'b1, 32'hFFFF_FFFF, STATUS_EMPTY, 11'd0, 11'd0},
        {KIND_PUSH_ONE, 32'hFFFF_FFFF, 1'b0, 56'd0},
        {KIND_PUSH_ONE, 32'h0000_0000, 1'b0, 56'd0},
        {KIND_PUSH_TWO, 32'h5555_5555, 1'b0, 56'd0},
        {KIND_PUSH_TWO, 32'hAAAA_AAAA, 1'b0, 56'd0},
        {KIND_PUSH_ONE, 32'h8000_0000, 1'b0, 56'd0},
        {KIND_POP_ONE,  32'hDEAD_BEEF, 1'b0, 56'd0},
        {KIND_POP_TWO,  32'h1234_5678, 1'b0, 56'd0},
        {KIND_POP_ONE,  32'hAAAA_AAAA, 1'b0, 56'd0},
        {KIND_PUSH_TWO, 32'h7FFF_FFFF, 1'b0, 56'd0},
        {KIND_POP_TWO,  32'h0000_0001, 1'b0, 56'd0},
        {KIND_POP_TWO,  32'hFFFF_FFFE, 1'b0, 56'd0},
        {KIND_POP_ONE,  32'h0000_0000, 1'b0, 56'd0},
        {KIND_POP_ONE,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, STATUS_EMPTY, 11'd0, 11'd0},
        {KIND_POP_TWO,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, STATUS_EMPTY, 11'd0, 11'd0}
    };

    dual_stack_shared_memory_top #(
        .DEPTH(Depth)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_push_value(s_push_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pop_value (m_pop_value),
        .m_status    (m_status),
        .m_height_one(m_height_one),
        .m_height_two(m_height_two)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic stack_result_t stack_apply(logic [KindW-1:0] kind,
                                                  logic [WordW-1:0] value);
        stack_result_t r;
        r.pop_value = '1;
        r.status    = STATUS_OK;
        case (kind)
            KIND_PUSH_ONE: begin
                if (level_one + level_two >= Depth) begin
                    r.status = STATUS_FULL;
                end else begin
                    shadow_words[level_one] = value;
                    level_one++;
                end
            end
            KIND_PUSH_TWO: begin
                if (level_one + level_two >= Depth) begin
                    r.status = STATUS_FULL;
                end else begin
                    shadow_words[Depth - 1 - level_two] = value;
                    level_two++;
                end
            end
            KIND_POP_ONE: begin
                if (level_one == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    level_one--;
                    r.pop_value = shadow_words[level_one];
                end
            end
            default: begin
                if (level_two == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.pop_value = shadow_words[Depth - level_two];
                    level_two--;
                end
            end
        endcase
        r.height_one = level_one[HeightW-1:0];
        r.height_two = level_two[HeightW-1:0];
        return r;
    endfunction

    function automatic logic [WordW-1:0] rand_word();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pace_limit();
        case ($urandom_range(2))
            0:       return 0;
            1:       return 3;
            default: return 19;
        endcase
    endfunction

    task automatic report(string field, logic [WordW-1:0] got, logic [WordW-1:0] want);
        $display("mismatch %0s: got %0h expected %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    task automatic send_request(logic [KindW-1:0] kind, logic [WordW-1:0] value,
                                logic known, stack_result_t known_result);
        int            gap;
        stack_result_t want;
        gap = $urandom_range(tx_max, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_push_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = stack_apply(kind, value);
        pending_q.push_back(known ? known_result : want);
    endtask

    task automatic send_random(logic [KindW-1:0] kind);
        send_request(kind, rand_word(), 1'b0, '0);
    endtask

    task automatic settle_output();
        s_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        stack_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_q.size() == 0) begin
                report("unexpected result", m_pop_value, '0);
            end else begin
                want = pending_q.pop_front();
                if (m_pop_value !== want.pop_value)
                    report("pop_value", m_pop_value, want.pop_value);
                if (m_status !== want.status)
                    report("status", WordW'(m_status), WordW'(want.status));
                if (m_height_one !== want.height_one)
                    report("height_one", WordW'(m_height_one), WordW'(want.height_one));
                if (m_height_two !== want.height_two)
                    report("height_two", WordW'(m_height_two), WordW'(want.height_two));
            end
        end
    end

    initial begin
        int stall;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            stall = $urandom_range(rx_max, 0);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        int               n;
        int               roll;
        logic [KindW-1:0] kind;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_max = pace_limit();
        rx_max = pace_limit();
        for (int i = 0; i < TableRows; i++) begin
            send_request(request_table[i].kind, request_table[i].value,
                         request_table[i].known, request_table[i].result);
        end
        settle_output();

        // mixed traffic near empty
        for (int i = 0; i < 120; i++) begin
            if (i % 40 == 0) begin
                tx_max = pace_limit();
                rx_max = pace_limit();
            end
            kind = KindW'($urandom_range(3));
            send_random(kind);
        end
        settle_output();

        // fill the memory from stack one
        n = 0;
        while (level_one + level_two < Depth && n < 3000) begin
            if (n % 64 == 0) begin
                tx_max = pace_limit();
                rx_max = pace_limit();
            end
            send_random(($urandom_range(99) < 92) ? KIND_PUSH_ONE : KIND_POP_ONE);
            n++;
        end
        for (int i = 0; i < 12; i++)
            send_random($urandom_range(1) ? KIND_PUSH_ONE : KIND_PUSH_TWO);
        settle_output();

        // move part of the contents over to stack two
        n = 0;
        while ((level_one != 0 || level_two != Depth) && n < 600) begin
            if (n % 64 == 0) begin
                tx_max = pace_limit();
                rx_max = pace_limit();
            end
            roll = $urandom_range(99);
            if (roll < 4)
                kind = KindW'($urandom_range(3));
            else if (roll < 52 && level_one != 0)
                kind = KIND_POP_ONE;
            else
                kind = KIND_PUSH_TWO;
            send_random(kind);
            n++;
        end
        for (int i = 0; i < 16; i++) begin
            kind = KindW'($urandom_range(3));
            send_random(kind);
        end

        settle_output();
        repeat (16) @(posedge aclk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
src/dssm_pkg.sv
src/dssm_ram.sv
src/dssm_ctrl.sv
src/dssm_datapath.sv
src/dual_stack_shared_memory_top.sv
tb/tb_dual_stack_shared_memory_top.sv
